// File: hdl/rffsa_pkg.sv
// Shared types and constants of the row first-fit span allocator.
// Depends on nothing; rffsa_scan, the top level and the testbench import it.
package rffsa_pkg;

    localparam int RUN_W      = 7;   // run lengths and column counts
    localparam int CFG_ROWS_W = 9;
    localparam int CFG_COLS_W = 7;
    localparam int ROW_OUT_W  = 8;
    localparam int CNT_W      = 17;  // row counters, wide enough for any row plus one group
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ERASE = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [9:0] word_id;
        logic [6:0] word_len;
    } in_word_t;

    typedef struct packed {
        logic                 found;
        logic [ROW_OUT_W-1:0] row_index;
    } out_word_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_G_RD,
        S_G_CHK,
        S_R_RD,
        S_R_CHK,
        S_SCAN,
        S_PLACE,
        S_ID_CHK,
        S_E_MOD,
        S_E_WR,
        S_RF_SCAN,
        S_GM_RD,
        S_GM_CHK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic used;
    } scan_ctrl_t;

    typedef struct packed {
        logic             hit;
        logic [RUN_W-1:0] best;
    } scan_stat_t;

endpackage

// File: hdl/rffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rffsa_scan.sv
// Shared column scan unit: counts the current free run and the longest run,
// and flags when the run reaches the requested length. Uses rffsa_pkg.
module rffsa_scan
    import rffsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  logic [RUN_W-1:0] len,
    output scan_stat_t       stat
);

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic [RUN_W-1:0] best_reg;
    logic [RUN_W-1:0] best_next;
    logic [RUN_W-1:0] run_inc;

    assign run_inc = run_reg + RUN_W'(1);

    // advance the run on one cell, or restart it
    always_comb
    begin
        run_next  = run_reg;
        best_next = best_reg;
        if (ctrl.clear)
        begin
            run_next  = '0;
            best_next = '0;
        end
        else if (ctrl.step)
        begin
            run_next = ctrl.used ? '0 : run_inc;
            if (run_next > best_reg)
            begin
                best_next = run_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            best_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            best_reg <= best_next;
        end
    end

    assign stat.hit  = ctrl.step && !ctrl.clear && !ctrl.used && (run_inc == len);
    assign stat.best = best_reg;

endmodule

// File: hdl/row_first_fit_span_allocator.sv
// Top level of the row first-fit span allocator: sequencer, stores and ports.
// Depends on rffsa_pkg, rffsa_ram and rffsa_scan.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes one request word:
//   mode 0 places a span of word_len cells under word_id in the lowest row
//   that holds a long enough free run, at its leftmost such run; mode 1 frees
//   the span recorded under word_id. Each request gives one result word on
//   the output channel (out_valid / out_stall / out_word): found and the row.
//   One request is worked at a time; in_stall is high while it runs.
//   A failed length check or unknown id skips the search. A write reads the
//   group summaries, then the row summaries of a fitting group, then scans
//   the columns of a fitting row; it then rescans that row and reads the row
//   summaries of its group to refresh the row and group summaries. An erase
//   frees the cells and does the same refresh. The single column scan unit and
//   the one read port of each summary memory serve these steps in turn.
//   A finished result sits in the output register while the next request is
//   taken; a request completes only once that register is free.
//   After reset, and after any register write over the APB port, a clearing
//   pass empties every store; in_stall is high throughout.
module row_first_fit_span_allocator
    import rffsa_pkg::*;
#(
    parameter int ROWS           = 256,
    parameter int COLS           = 64,
    parameter int ROWS_PER_GROUP = 64,
    parameter int ID_BITS        = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int RW        = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int CW        = COLS > 1 ? $clog2(COLS) : 1;
    localparam int CXW       = CW > RUN_W ? CW : RUN_W;
    localparam int NG        = (ROWS + ROWS_PER_GROUP - 1) / ROWS_PER_GROUP;
    localparam int GW        = NG > 1 ? $clog2(NG) : 1;
    localparam int NIDS      = 1 << ID_BITS;
    localparam int IDXW      = ID_BITS > 10 ? ID_BITS : 10;
    localparam int REC_W     = 1 + RW + GW + RUN_W + RUN_W;
    localparam int CLR_DEPTH = ROWS > NIDS ? ROWS : NIDS;
    localparam int CLRW      = CLR_DEPTH > 1 ? $clog2(CLR_DEPTH) : 1;
    localparam int ROWS_RST  = ROWS < 256 ? ROWS : 256;
    localparam int COLS_RST  = COLS < 64 ? COLS : 64;

    // registers
    state_t                state_reg, state_next;
    logic [CFG_ROWS_W-1:0] rows_reg, rows_next;
    logic [CFG_COLS_W-1:0] cols_reg, cols_next;
    logic [CLRW-1:0]       clr_reg, clr_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [RUN_W-1:0]      len_reg, len_next;
    logic [GW-1:0]         g_reg, g_next;
    logic [CNT_W-1:0]      gbase_reg, gbase_next;
    logic [CNT_W-1:0]      r_reg, r_next;
    logic [CNT_W-1:0]      rr_reg, rr_next;
    logic [RUN_W-1:0]      c_reg, c_next;
    logic [RUN_W-1:0]      start_reg, start_next;
    logic [COLS-1:0]       word_reg, word_next;
    logic [RUN_W-1:0]      gmax_reg, gmax_next;
    logic                  found_reg, found_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_word_reg, out_word_next;

    // memory ports
    logic            bm_we;
    logic [RW-1:0]   bm_waddr, bm_raddr;
    logic [COLS-1:0] bm_wdata, bm_rdata;
    logic             rl_we;
    logic [RW-1:0]    rl_waddr, rl_raddr;
    logic [RUN_W-1:0] rl_wdata, rl_rdata;
    logic             gl_we;
    logic [GW-1:0]    gl_waddr, gl_raddr;
    logic [RUN_W-1:0] gl_wdata, gl_rdata;
    logic               id_we;
    logic [ID_BITS-1:0] id_waddr, id_raddr;
    logic [REC_W-1:0]   id_wdata, id_rdata;

    scan_ctrl_t scan_ctrl;
    scan_stat_t scan_stat;

    // helpers
    logic              in_acc, out_free, cfg_wr, len_bad;
    logic [IDXW-1:0]   id_ext;
    logic [ID_BITS-1:0] in_id;
    logic [CNT_W-1:0]  rows_ext, gsum, gend;
    logic              grp_past, row_past, col_done, cell_used;
    logic [CXW-1:0]    c_ext;
    logic [RUN_W-1:0]  hit_start;
    logic              rec_valid;
    logic [RW-1:0]     rec_row;
    logic [GW-1:0]     rec_grp;
    logic [RUN_W-1:0]  rec_start, rec_len;
    logic              clr_last;
    logic [CFG_ROWS_W-1:0] wr_rows;
    logic [CFG_COLS_W-1:0] wr_cols;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_wr    = psel && penable && pwrite;
    assign id_ext    = IDXW'(in_word.word_id);
    assign in_id     = id_ext[ID_BITS-1:0];
    assign len_bad   = (in_word.word_len == '0) || (in_word.word_len > cols_reg);
    assign rows_ext  = CNT_W'(rows_reg);
    assign gsum      = gbase_reg + CNT_W'(ROWS_PER_GROUP);
    assign gend      = (gsum < rows_ext) ? gsum : rows_ext;
    assign grp_past  = (gbase_reg >= rows_ext);
    assign row_past  = (r_reg >= gend);
    assign col_done  = (c_reg >= cols_reg);
    assign c_ext     = CXW'(c_reg);
    assign cell_used = word_reg[c_ext[CW-1:0]];
    assign hit_start = c_reg + RUN_W'(1) - len_reg;
    assign clr_last  = (clr_reg == CLRW'(CLR_DEPTH - 1));
    assign {rec_valid, rec_row, rec_grp, rec_start, rec_len} = id_rdata;

    // saturate register writes to the grid size
    always_comb
    begin
        wr_rows = pwdata[CFG_ROWS_W-1:0];
        if (wr_rows == '0)
        begin
            wr_rows = CFG_ROWS_W'(1);
        end
        else if (32'(wr_rows) > ROWS)
        begin
            wr_rows = CFG_ROWS_W'(ROWS);
        end
        wr_cols = pwdata[CFG_COLS_W-1:0];
        if (wr_cols == '0)
        begin
            wr_cols = CFG_COLS_W'(1);
        end
        else if (32'(wr_cols) > COLS)
        begin
            wr_cols = CFG_COLS_W'(COLS);
        end
    end

    // register file: write and read back
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_ROWS: rows_next = wr_rows;
                REG_COLS: cols_next = wr_cols;
                default:  rows_next = rows_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_ROWS) ? DATA_W'(rows_reg) : DATA_W'(cols_reg);
    assign pready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_word.mode == MODE_ERASE)
                    begin
                        state_next = S_ID_CHK;
                    end
                    else if (len_bad)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_G_RD;
                    end
                end
            end
            S_G_RD:    state_next = grp_past ? S_FINISH : S_G_CHK;
            S_G_CHK:   state_next = (len_reg > gl_rdata) ? S_G_RD : S_R_RD;
            S_R_RD:    state_next = row_past ? S_G_RD : S_R_CHK;
            S_R_CHK:   state_next = (len_reg > rl_rdata) ? S_R_RD : S_SCAN;
            S_SCAN:
            begin
                if (col_done)
                begin
                    state_next = S_R_RD;
                end
                else if (scan_stat.hit)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:   state_next = S_RF_SCAN;
            S_ID_CHK:  state_next = rec_valid ? S_E_MOD : S_FINISH;
            S_E_MOD:   state_next = S_E_WR;
            S_E_WR:    state_next = S_RF_SCAN;
            S_RF_SCAN: state_next = col_done ? S_GM_RD : S_RF_SCAN;
            S_GM_RD:   state_next = (rr_reg >= gend) ? S_FINISH : S_GM_CHK;
            S_GM_CHK:  state_next = S_GM_RD;
            S_FINISH:  state_next = out_free ? S_IDLE : S_FINISH;
            default:   state_next = S_CLEAR;
        endcase
        if (cfg_wr)
        begin
            state_next = S_CLEAR;
        end
    end

    // memory, scan unit and datapath controls
    always_comb
    begin
        bm_we      = 1'b0;
        bm_waddr   = r_reg[RW-1:0];
        bm_wdata   = word_reg;
        bm_raddr   = r_reg[RW-1:0];
        rl_we      = 1'b0;
        rl_waddr   = r_reg[RW-1:0];
        rl_wdata   = scan_stat.best;
        rl_raddr   = r_reg[RW-1:0];
        gl_we      = 1'b0;
        gl_waddr   = g_reg;
        gl_wdata   = gmax_reg;
        gl_raddr   = g_reg;
        id_we      = 1'b0;
        id_waddr   = id_reg;
        id_wdata   = {1'b1, r_reg[RW-1:0], g_reg, start_reg, len_reg};
        id_raddr   = in_id;
        scan_ctrl  = '0;
        scan_ctrl.used = cell_used;

        clr_next   = clr_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        g_next     = g_reg;
        gbase_next = gbase_reg;
        r_next     = r_reg;
        rr_next    = rr_reg;
        c_next     = c_reg;
        start_next = start_reg;
        word_next  = word_reg;
        gmax_next  = gmax_reg;
        found_next = found_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every store back to its empty value
                bm_waddr = clr_reg[RW-1:0];
                bm_wdata = '0;
                bm_we    = (32'(clr_reg) < ROWS);
                rl_waddr = clr_reg[RW-1:0];
                rl_wdata = RUN_W'(cols_reg);
                rl_we    = (32'(clr_reg) < ROWS);
                gl_waddr = clr_reg[GW-1:0];
                gl_wdata = RUN_W'(cols_reg);
                gl_we    = (32'(clr_reg) < NG);
                id_waddr = clr_reg[ID_BITS-1:0];
                id_wdata = '0;
                id_we    = (32'(clr_reg) < NIDS);
                clr_next = clr_reg + CLRW'(1);
            end
            S_IDLE:
            begin
                id_next    = in_id;
                len_next   = in_word.word_len;
                found_next = 1'b0;
                g_next     = '0;
                gbase_next = '0;
            end
            S_G_RD:
            begin
                gl_raddr = g_reg;
            end
            S_G_CHK:
            begin
                if (len_reg > gl_rdata)
                begin
                    g_next     = g_reg + GW'(1);
                    gbase_next = gsum;
                end
                else
                begin
                    r_next = gbase_reg;
                end
            end
            S_R_RD:
            begin
                if (row_past)
                begin
                    g_next     = g_reg + GW'(1);
                    gbase_next = gsum;
                end
            end
            S_R_CHK:
            begin
                if (len_reg > rl_rdata)
                begin
                    r_next = r_reg + CNT_W'(1);
                end
                else
                begin
                    word_next       = bm_rdata;
                    c_next          = '0;
                    scan_ctrl.clear = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (col_done)
                begin
                    r_next = r_reg + CNT_W'(1);
                end
                else
                begin
                    scan_ctrl.step = 1'b1;
                    c_next         = c_reg + RUN_W'(1);
                    if (scan_stat.hit)
                    begin
                        // mark the run from its start through this column
                        start_next = hit_start;
                        for (int k = 0; k < COLS; k++)
                        begin
                            if (k >= int'(hit_start) && k <= int'(c_reg))
                            begin
                                word_next[k] = 1'b1;
                            end
                        end
                    end
                end
            end
            S_PLACE:
            begin
                bm_we           = 1'b1;
                id_we           = 1'b1;
                c_next          = '0;
                scan_ctrl.clear = 1'b1;
            end
            S_ID_CHK:
            begin
                r_next     = CNT_W'(rec_row);
                g_next     = rec_grp;
                gbase_next = CNT_W'(rec_grp * ROWS_PER_GROUP);
                start_next = rec_start;
                len_next   = rec_len;
                bm_raddr   = rec_row;
            end
            S_E_MOD:
            begin
                // free the recorded cells and drop the record
                word_next = bm_rdata;
                for (int k = 0; k < COLS; k++)
                begin
                    if (k >= int'(start_reg) && k < int'(start_reg) + int'(len_reg))
                    begin
                        word_next[k] = 1'b0;
                    end
                end
                id_we    = 1'b1;
                id_wdata = '0;
            end
            S_E_WR:
            begin
                bm_we           = 1'b1;
                c_next          = '0;
                scan_ctrl.clear = 1'b1;
            end
            S_RF_SCAN:
            begin
                if (col_done)
                begin
                    rl_we     = 1'b1;
                    rr_next   = gbase_reg;
                    gmax_next = '0;
                end
                else
                begin
                    scan_ctrl.step = 1'b1;
                    c_next         = c_reg + RUN_W'(1);
                end
            end
            S_GM_RD:
            begin
                rl_raddr = rr_reg[RW-1:0];
                if (rr_reg >= gend)
                begin
                    gl_we      = 1'b1;
                    found_next = 1'b1;
                end
            end
            S_GM_CHK:
            begin
                if (rl_rdata > gmax_reg)
                begin
                    gmax_next = rl_rdata;
                end
                rr_next = rr_reg + CNT_W'(1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.found     = found_reg;
                    out_word_next.row_index = found_reg ? r_reg[ROW_OUT_W-1:0] : '0;
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase

        if (cfg_wr)
        begin
            clr_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rows_reg      <= CFG_ROWS_W'(ROWS_RST);
            cols_reg      <= CFG_COLS_W'(COLS_RST);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        len_reg      <= len_next;
        g_reg        <= g_next;
        gbase_reg    <= gbase_next;
        r_reg        <= r_next;
        rr_reg       <= rr_next;
        c_reg        <= c_next;
        start_reg    <= start_next;
        word_reg     <= word_next;
        gmax_reg     <= gmax_next;
        found_reg    <= found_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    rffsa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .len   (len_reg),
        .stat  (scan_stat)
    );

    rffsa_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    rffsa_ram #(.WIDTH(RUN_W), .DEPTH(ROWS)) u_row_run (
        .clk   (clk),
        .we    (rl_we),
        .waddr (rl_waddr),
        .wdata (rl_wdata),
        .raddr (rl_raddr),
        .rdata (rl_rdata)
    );

    rffsa_ram #(.WIDTH(RUN_W), .DEPTH(NG)) u_grp_run (
        .clk   (clk),
        .we    (gl_we),
        .waddr (gl_waddr),
        .wdata (gl_wdata),
        .raddr (gl_raddr),
        .rdata (gl_rdata)
    );

    rffsa_ram #(.WIDTH(REC_W), .DEPTH(NIDS)) u_id_rec (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

endmodule

// File: dv/testbench.sv
// Testbench of the row first-fit span allocator: directed table, saturation checks, then random requests.
// Depends on rffsa_pkg and row_first_fit_span_allocator; checks against its own grid model.
`timescale 1ns / 1ps

module testbench;
    import rffsa_pkg::*;

    localparam int ROWS           = 256;
    localparam int COLS           = 64;
    localparam int ROWS_PER_GROUP = 64;
    localparam int ID_BITS        = 10;
    localparam int NGROUPS        = (ROWS + ROWS_PER_GROUP - 1) / ROWS_PER_GROUP;
    localparam int NIDS           = 1 << ID_BITS;
    localparam int SETTLE         = COLS + 2 * ROWS_PER_GROUP + 40;

    typedef struct {
        bit       live;
        int       row;
        int       start;
        int       len;
    } span_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_word_t          in_word;
    logic              out_valid;
    logic              out_stall;
    out_word_t         out_word;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // grid model
    bit [COLS-1:0] grid [ROWS];
    span_t         spans [NIDS];
    int            rows_live;
    int            cols_live;

    out_word_t     pending_results [$];
    int            fail_count;
    int            send_idle_pct;
    int            recv_stall_pct;

    row_first_fit_span_allocator #(
        .ROWS(ROWS), .COLS(COLS), .ROWS_PER_GROUP(ROWS_PER_GROUP), .ID_BITS(ID_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Clear the grid and the id records
    function automatic void clear_grid();
        for (int r = 0; r < ROWS; r++)
            grid[r] = '0;
        for (int i = 0; i < NIDS; i++)
            spans[i].live = 1'b0;
    endfunction

    // Place or free a span and return the result word
    function automatic out_word_t allocate_span(in_word_t w);
        out_word_t res;
        int        id;
        int        run;
        res = '0;
        id = int'(w.word_id) % NIDS;
        if (w.mode == MODE_ERASE)
        begin
            if (!spans[id].live)
                return res;
            for (int c = spans[id].start; c < spans[id].start + spans[id].len && c < COLS; c++)
                grid[spans[id].row][c] = 1'b0;
            spans[id].live = 1'b0;
            res.found = 1'b1;
            res.row_index = spans[id].row[7:0];
            return res;
        end
        if (w.word_len == 0 || int'(w.word_len) > cols_live)
            return res;
        // exact search gives the same answer as the summary-steered one
        for (int r = 0; r < rows_live; r++)
        begin
            run = 0;
            for (int c = 0; c < cols_live; c++)
            begin
                if (!grid[r][c])
                begin
                    run++;
                    if (run == int'(w.word_len))
                    begin
                        for (int k = c + 1 - run; k <= c; k++)
                            grid[r][k] = 1'b1;
                        spans[id].live = 1'b1;
                        spans[id].row = r;
                        spans[id].start = c + 1 - run;
                        spans[id].len = run;
                        res.found = 1'b1;
                        res.row_index = r[7:0];
                        return res;
                    end
                end
                else
                    run = 0;
            end
        end
        return res;
    endfunction

    // Send one request word; hold it until accepted
    task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
        out_word_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        res = allocate_span(w);
        if (typed && res != typed_res)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("table row disagrees with model: %p vs %p", typed_res, res);
        end
        pending_results.push_back(res);
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 2_000_000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write a register over the APB port, then update and clear the grid model
    task automatic write_reg(logic idx, int value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROWS)
            rows_live = (value & 'h1ff) < 1 ? 1 : ((value & 'h1ff) > ROWS ? ROWS : value & 'h1ff);
        else
            cols_live = (value & 'h7f) < 1 ? 1 : ((value & 'h7f) > COLS ? COLS : value & 'h7f);
        clear_grid();
        @(negedge clk);
    endtask

    function automatic in_word_t mk(logic m, int id, int len);
        in_word_t w;
        w.mode = m;
        w.word_id = id[9:0];
        w.word_len = len[6:0];
        return w;
    endfunction

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %p", out_word);
            end
            else
            begin
                out_word_t want;
                want = pending_results.pop_front();
                if (out_word.found !== want.found || out_word.row_index !== want.row_index)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected found %0d row %0d, got found %0d row %0d",
                                 want.found, want.row_index, out_word.found, out_word.row_index);
                end
            end
        end
    end

    // Receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Random phase: mostly writes and erases over a range of ids, with some raw random words
    task automatic random_phase(int n, int id_span, int max_len);
        in_word_t w;
        int       pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                w = mk(MODE_WRITE, $urandom_range(id_span - 1), $urandom_range(max_len, 1));
            else if (pick < 90)
                w = mk(MODE_ERASE, $urandom_range(id_span - 1), 0);
            else
            begin
                w = in_word_t'(($bits(in_word_t))'($urandom));
                if ($urandom_range(3) == 0)
                    w.word_id = 10'h3ff;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    initial
    begin
        typedef struct {
            logic m;
            int   id;
            int   len;
            bit   typed;
            bit   f;
            int   row;
        } stim_row_t;
        stim_row_t table_rows [$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rows_live = ROWS;
        cols_live = COLS;
        clear_grid();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed table on a small grid: 2 rows of 4 columns
        write_reg(REG_ROWS, 2);
        write_reg(REG_COLS, 4);
        table_rows = '{
            '{MODE_ERASE, 5,    0, 1, 0, 0},  // unknown id
            '{MODE_WRITE, 1,    0, 1, 0, 0},  // zero length
            '{MODE_WRITE, 1,    5, 1, 0, 0},  // too long
            '{MODE_WRITE, 1,  127, 1, 0, 0},
            '{MODE_WRITE, 0,    4, 1, 1, 0},  // full row
            '{MODE_WRITE, 1023, 1, 1, 1, 1},
            '{MODE_WRITE, 2,    3, 1, 1, 1},
            '{MODE_WRITE, 3,    1, 1, 0, 0},  // no room
            '{MODE_ERASE, 0,    0, 1, 1, 0},
            '{MODE_ERASE, 0,    0, 1, 0, 0},
            '{MODE_WRITE, 1023, 2, 1, 1, 0},  // existing id overwritten
            '{MODE_ERASE, 1023, 0, 1, 1, 0},
            '{MODE_ERASE, 1023, 0, 1, 0, 0},
            '{MODE_WRITE, 7,    2, 0, 0, 0},
            '{MODE_WRITE, 8,    1, 0, 0, 0},
            '{MODE_ERASE, 2,    0, 0, 0, 0},
            '{MODE_WRITE, 9,    3, 0, 0, 0}
        };
        foreach (table_rows[i])
            send_word(mk(table_rows[i].m, table_rows[i].id, table_rows[i].len),
                      table_rows[i].typed,
                      '{found: table_rows[i].f, row_index: table_rows[i].row[7:0]});
        drain();

        // out-of-range values saturate: zero to one, too large to the full size
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 'h7f);
        send_word(mk(MODE_WRITE, 512, 64), 1'b0, '0);
        send_word(mk(MODE_WRITE, 513, 64), 1'b0, '0);
        send_word(mk(MODE_WRITE, 514, 1), 1'b0, '0);
        drain();
        write_reg(REG_ROWS, 'h1ff);
        write_reg(REG_COLS, 0);
        send_word(mk(MODE_WRITE, 3, 1), 1'b0, '0);
        send_word(mk(MODE_WRITE, 4, 2), 1'b0, '0);
        drain();

        // random phases across idling patterns and sizes
        write_reg(REG_ROWS, 6);
        write_reg(REG_COLS, 8);
        random_phase(110, 24, 9);
        drain();
        send_idle_pct = 47;
        write_reg(REG_ROWS, 70);
        write_reg(REG_COLS, 16);
        random_phase(110, 96, 17);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 47;
        write_reg(REG_ROWS, 130);
        write_reg(REG_COLS, 64);
        random_phase(110, 300, 64);
        drain();
        send_idle_pct = 34;
        recv_stall_pct = 34;
        write_reg(REG_ROWS, 256);
        write_reg(REG_COLS, 5);
        random_phase(110, 1024, 6);
        drain();

        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
